### rtl/srpq_pkg.sv
// srpq_pkg: shared types and codes for the sorted priority queue
// no dependencies; imported by the interfaces, the cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package srpq_pkg;

    typedef enum logic
    {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/srpq_in_if.sv
// srpq_in_if: request channel of the priority queue, valid/ready handshake
// depends on srpq_pkg for the operation code
`timescale 1ns / 1ps
`default_nettype none

interface srpq_in_if
    import srpq_pkg::*;
#(
    parameter int KEY_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 32
);

    logic                            valid;
    logic                            ready;
    op_t                             op;
    logic signed [KEY_WIDTH-1:0]     item_key;
    logic        [PAYLOAD_WIDTH-1:0] item_payload;

    modport source
    (
        output valid,
        input  ready,
        output op,
        output item_key,
        output item_payload
    );

    modport sink
    (
        input  valid,
        output ready,
        input  op,
        input  item_key,
        input  item_payload
    );

endinterface

`default_nettype wire

### rtl/srpq_out_if.sv
// srpq_out_if: result channel of the priority queue, valid/ready handshake
// depends on srpq_pkg for the status code
`timescale 1ns / 1ps
`default_nettype none

interface srpq_out_if
    import srpq_pkg::*;
#(
    parameter int KEY_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 32,
    parameter int COUNT_WIDTH   = 7
);

    logic                            valid;
    logic                            ready;
    logic signed [KEY_WIDTH-1:0]     out_key;
    logic        [PAYLOAD_WIDTH-1:0] out_payload;
    logic                            out_valid;
    status_t                         status;
    logic        [COUNT_WIDTH-1:0]   entry_count;
    logic                            is_empty;
    logic                            is_full;

    modport source
    (
        output valid,
        input  ready,
        output out_key,
        output out_payload,
        output out_valid,
        output status,
        output entry_count,
        output is_empty,
        output is_full
    );

    modport sink
    (
        input  valid,
        output ready,
        input  out_key,
        input  out_payload,
        input  out_valid,
        input  status,
        input  entry_count,
        input  is_empty,
        input  is_full
    );

endinterface

`default_nettype wire

### rtl/srpq_cell.sv
// srpq_cell: one slot of the sorted chain, holds a key and payload
// depends on srpq_pkg for the shift control struct
`timescale 1ns / 1ps
`default_nettype none

module srpq_cell
    import srpq_pkg::*;
#(
    parameter int KEY_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 32
)
(
    input  wire logic                            clk,
    input  wire cell_ctrl_t                      ctrl,
    input  wire logic                            occupied,
    input  wire logic signed [KEY_WIDTH-1:0]     new_key,
    input  wire logic        [PAYLOAD_WIDTH-1:0] new_payload,
    input  wire logic                            left_take,
    input  wire logic signed [KEY_WIDTH-1:0]     left_key,
    input  wire logic        [PAYLOAD_WIDTH-1:0] left_payload,
    input  wire logic signed [KEY_WIDTH-1:0]     right_key,
    input  wire logic        [PAYLOAD_WIDTH-1:0] right_payload,
    output      logic                            take,
    output      logic signed [KEY_WIDTH-1:0]     key,
    output      logic        [PAYLOAD_WIDTH-1:0] payload
);

    logic signed [KEY_WIDTH-1:0]     key_reg;
    logic signed [KEY_WIDTH-1:0]     key_next;
    logic        [PAYLOAD_WIDTH-1:0] payload_reg;
    logic        [PAYLOAD_WIDTH-1:0] payload_next;

    // new entry goes before the first slot that is free or holds a larger key
    assign take    = !occupied || (new_key < key_reg);
    assign key     = key_reg;
    assign payload = payload_reg;

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctrl.deq)
        begin
            key_next     = right_key;
            payload_next = right_payload;
        end
        else if (ctrl.enq && take)
        begin
            if (left_take)
            begin
                key_next     = left_key;
                payload_next = left_payload;
            end
            else
            begin
                key_next     = new_key;
                payload_next = new_payload;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

endmodule

`default_nettype wire

### rtl/sorted_ring_priority_queue.sv
// sorted_ring_priority_queue: a row of DEPTH cells kept in ascending key order
// a request's result is registered and shown in the cycle after its transaction
// throughput: one request per cycle via each cell's parallel compare, unless rsp stalls
// reset: entry count and result valid clear at once; cell contents are not reset
// depends on srpq_pkg, srpq_in_if, srpq_out_if and srpq_cell
`timescale 1ns / 1ps
`default_nettype none

module sorted_ring_priority_queue
    import srpq_pkg::*;
#(
    parameter int DEPTH         = 64,
    parameter int KEY_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    srpq_in_if.sink   req,
    srpq_out_if.source rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic                            accept;
    logic                            full;
    logic                            empty;
    logic                            enq_ok;
    logic                            deq_ok;
    cell_ctrl_t                      ctrl;

    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;

    logic                            rsp_valid_reg;
    logic                            rsp_valid_next;
    logic signed [KEY_WIDTH-1:0]     key_reg;
    logic signed [KEY_WIDTH-1:0]     key_next;
    logic        [PAYLOAD_WIDTH-1:0] payload_reg;
    logic        [PAYLOAD_WIDTH-1:0] payload_next;
    logic                            hit_reg;
    logic                            hit_next;
    status_t                         status_reg;
    status_t                         status_next;
    logic [CW-1:0]                   count_out_reg;

    logic                            cell_take    [DEPTH];
    logic signed [KEY_WIDTH-1:0]     cell_key     [DEPTH];
    logic        [PAYLOAD_WIDTH-1:0] cell_payload [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == FULL_COUNT);
    assign empty     = (count_reg == '0);
    assign enq_ok    = accept && (req.op == OP_ENQUEUE) && !full;
    assign deq_ok    = accept && (req.op == OP_DEQUEUE) && !empty;
    assign ctrl.enq  = enq_ok;
    assign ctrl.deq  = deq_ok;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(i);
            logic                            l_take;
            logic signed [KEY_WIDTH-1:0]     l_key;
            logic        [PAYLOAD_WIDTH-1:0] l_payload;
            logic signed [KEY_WIDTH-1:0]     r_key;
            logic        [PAYLOAD_WIDTH-1:0] r_payload;

            if (i == 0)
            begin : g_first
                assign l_take    = 1'b0;
                assign l_key     = '0;
                assign l_payload = '0;
            end
            else
            begin : g_mid_l
                assign l_take    = cell_take[i-1];
                assign l_key     = cell_key[i-1];
                assign l_payload = cell_payload[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign r_key     = '0;
                assign r_payload = '0;
            end
            else
            begin : g_mid_r
                assign r_key     = cell_key[i+1];
                assign r_payload = cell_payload[i+1];
            end

            srpq_cell #(
                .KEY_WIDTH     (KEY_WIDTH),
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .clk           (clk),
                .ctrl          (ctrl),
                .occupied      (count_reg > IDX),
                .new_key       (req.item_key),
                .new_payload   (req.item_payload),
                .left_take     (l_take),
                .left_key      (l_key),
                .left_payload  (l_payload),
                .right_key     (r_key),
                .right_payload (r_payload),
                .take          (cell_take[i]),
                .key           (cell_key[i]),
                .payload       (cell_payload[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (enq_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        key_next     = '0;
        payload_next = '0;
        hit_next     = 1'b0;
        status_next  = STATUS_OK;
        if (deq_ok)
        begin
            key_next     = cell_key[0];
            payload_next = cell_payload[0];
            hit_next     = 1'b1;
        end
        else if (req.op == OP_ENQUEUE && full)
        begin
            status_next = STATUS_FULL;
        end
        else if (req.op == OP_DEQUEUE && empty)
        begin
            status_next = STATUS_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result payload, loaded on every transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg       <= key_next;
            payload_reg   <= payload_next;
            hit_reg       <= hit_next;
            status_reg    <= status_next;
            count_out_reg <= count_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.out_key     = key_reg;
    assign rsp.out_payload = payload_reg;
    assign rsp.out_valid   = hit_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = count_out_reg;
    assign rsp.is_empty    = (count_out_reg == '0);
    assign rsp.is_full     = (count_out_reg == FULL_COUNT);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above depth");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg && (count_out_reg == count_reg))
        else $error("result missing or count mismatch after transaction");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        enq_ok |=> count_reg == $past(count_reg) + 1'b1)
        else $error("enqueue did not grow the queue");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CW'(2) |-> cell_key[0] <= cell_key[1])
        else $error("head entries out of order");

    a_empty_deq: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.op == OP_DEQUEUE) && empty
        |=> (status_reg == STATUS_EMPTY) && !hit_reg)
        else $error("dequeue on empty not flagged");

endmodule

`default_nettype wire
